// File: rtl/wssf_pkg.sv
// ----------------------------------------------------------------------------
// wssf_pkg
// Types and constants shared by the WAV sample span finder modules.
// ----------------------------------------------------------------------------
package wssf_pkg;

    // Input request: one file byte, final byte flagged
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    // Output request: sample span or raw fallback
    typedef struct packed {
        logic [31:0] sample_offset;
        logic [31:0] sample_length;
        logic        raw_fallback;
        logic [2:0]  status;
    } t_out_req;

    // Parse phases, one-hot
    typedef enum logic [7:0] {
        PH_RIFF = 8'b0000_0001,
        PH_FLEN = 8'b0000_0010,
        PH_WAVE = 8'b0000_0100,
        PH_NAME = 8'b0000_1000,
        PH_LEN  = 8'b0001_0000,
        PH_FMT  = 8'b0010_0000,
        PH_SKIP = 8'b0100_0000,
        PH_DONE = 8'b1000_0000
    } t_phase;

    typedef enum logic [2:0] {
        V_UNDECIDED  = 3'd0,
        V_BAD_RIFF   = 3'd1,
        V_BAD_WAVE   = 3'd2,
        V_SHORT_FMT  = 3'd3,
        V_BAD_FORMAT = 3'd4,
        V_FOUND      = 3'd6
    } t_verdict;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE = 3'd2;
    localparam logic [2:0] ST_NO_DATA  = 3'd5;

    localparam logic [31:0] TAG_FMT       = 32'h2074_6D66;  // "fmt "
    localparam logic [31:0] TAG_DATA      = 32'h6174_6164;  // "data"
    localparam logic [31:0] FMT_PCM_MONO  = 32'h0001_0001;  // format 1, 1 channel
    localparam logic [31:0] FMT_MIN_LEN   = 32'd16;
    localparam logic [31:0] FMT_BITS_8    = 32'd8;
    localparam logic [3:0]  FMT_IDX_BITS0 = 4'd14;
    localparam logic [3:0]  FMT_IDX_BITS1 = 4'd15;
    localparam logic [3:0]  FMT_IDX_LAST_HDR = 4'd3;

    // Summary of the parse at the final byte
    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] size;
        logic [2:0]  status;
    } t_span_info;

    function automatic logic [7:0] riff_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h52;  // R
            2'd1:    b = 8'h49;  // I
            2'd2:    b = 8'h46;  // F
            2'd3:    b = 8'h46;  // F
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] wave_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h57;  // W
            2'd1:    b = 8'h41;  // A
            2'd2:    b = 8'h56;  // V
            2'd3:    b = 8'h45;  // E
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/wssf_parser.sv
// ----------------------------------------------------------------------------
// wssf_parser
// Byte-wise RIFF/WAVE chunk walker; reports the span summary on the final byte.
// ----------------------------------------------------------------------------
module wssf_parser #(
    parameter int POSITION_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output wssf_pkg::t_span_info o_info
);
    import wssf_pkg::*;

    localparam logic [POSITION_BITS-1:0] PosMax = '1;

    t_phase                   r_phase,   n_phase;
    logic [POSITION_BITS-1:0] r_pos,     n_pos;
    logic [3:0]               r_idx,     n_idx;
    logic [31:0]              r_tag,     n_tag;
    logic [31:0]              r_fval,    n_fval;
    logic [POSITION_BITS-1:0] r_cend,    n_cend;
    logic [POSITION_BITS-1:0] r_foff,    n_foff;
    logic [31:0]              r_flen,    n_flen;
    t_verdict                 r_verdict, n_verdict;
    logic                     r_fmt_bad, n_fmt_bad;

    logic                     w_skip_done;
    t_phase                   w_phase;
    logic [3:0]               w_idx;
    logic [31:0]              w_tag;
    logic [31:0]              w_len_val;
    logic [POSITION_BITS:0]   w_body;
    logic [POSITION_BITS-1:0] w_body_sat;
    logic [32:0]              w_end_sum;
    logic [POSITION_BITS-1:0] w_end_sat;
    logic [4:0]               w_lane;

    // skipped chunk ends: the byte at its end position opens a new name
    assign w_skip_done = (r_phase == PH_SKIP) && (r_pos >= r_cend) && (r_cend != PosMax);
    assign w_phase     = w_skip_done ? PH_NAME : r_phase;
    assign w_idx       = w_skip_done ? 4'd0 : r_idx;
    assign w_tag       = w_skip_done ? 32'd0 : r_tag;
    assign w_lane      = {w_idx[1:0], 3'b000};

    assign w_len_val  = {i_byte, r_fval[23:0]};
    assign w_body     = {1'b0, r_pos} + (POSITION_BITS+1)'(1);
    assign w_body_sat = w_body[POSITION_BITS] ? PosMax : w_body[POSITION_BITS-1:0];
    assign w_end_sum  = 33'(w_body) + 33'(w_len_val);
    assign w_end_sat  = (w_end_sum > 33'(PosMax)) ? PosMax : w_end_sum[POSITION_BITS-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_tag     = r_tag;
        n_fval    = r_fval;
        n_cend    = r_cend;
        n_foff    = r_foff;
        n_flen    = r_flen;
        n_verdict = r_verdict;
        n_fmt_bad = r_fmt_bad;

        if (w_skip_done) begin
            n_phase = PH_NAME;
            n_idx   = 4'd0;
            n_tag   = 32'd0;
        end

        case (w_phase)
            PH_RIFF, PH_WAVE: begin
                if (i_byte != ((w_phase == PH_RIFF) ? riff_byte(w_idx[1:0])
                                                    : wave_byte(w_idx[1:0]))) begin
                    n_verdict = (w_phase == PH_RIFF) ? V_BAD_RIFF : V_BAD_WAVE;
                    n_phase   = PH_DONE;
                end else if (w_idx[1:0] == 2'd3) begin
                    n_idx   = 4'd0;
                    n_tag   = 32'd0;
                    n_phase = (w_phase == PH_RIFF) ? PH_FLEN : PH_NAME;
                end else begin
                    n_idx = w_idx + 4'd1;
                end
            end
            PH_FLEN: begin
                if (w_idx[1:0] == 2'd3) begin
                    n_idx   = 4'd0;
                    n_phase = PH_WAVE;
                end else begin
                    n_idx = w_idx + 4'd1;
                end
            end
            PH_NAME: begin
                n_tag = w_tag;
                n_tag[w_lane +: 8] = i_byte;
                if (w_idx[1:0] == 2'd3) begin
                    n_idx   = 4'd0;
                    n_fval  = 32'd0;
                    n_phase = PH_LEN;
                end else begin
                    n_idx = w_idx + 4'd1;
                end
            end
            PH_LEN: begin
                n_fval[w_lane +: 8] = i_byte;
                if (w_idx[1:0] == 2'd3) begin
                    n_idx = 4'd0;
                    if (r_tag == TAG_FMT) begin
                        if (w_len_val < FMT_MIN_LEN) begin
                            n_verdict = V_SHORT_FMT;
                            n_phase   = PH_DONE;
                        end else begin
                            n_cend    = w_end_sat;
                            n_fval    = 32'd0;
                            n_fmt_bad = 1'b0;
                            n_phase   = PH_FMT;
                        end
                    end else if (r_tag == TAG_DATA) begin
                        n_foff    = w_body_sat;
                        n_flen    = w_len_val;
                        n_verdict = V_FOUND;
                        n_phase   = PH_DONE;
                    end else begin
                        n_cend  = w_end_sat;
                        n_phase = PH_SKIP;
                    end
                end else begin
                    n_idx = w_idx + 4'd1;
                end
            end
            PH_FMT: begin
                if (w_idx < 4'd4) begin
                    n_fval[w_lane +: 8] = i_byte;
                    if ((w_idx == FMT_IDX_LAST_HDR) && (w_len_val != FMT_PCM_MONO)) begin
                        n_fmt_bad = 1'b1;
                    end
                    n_idx = w_idx + 4'd1;
                end else if (w_idx == FMT_IDX_BITS0) begin
                    n_fval = {24'd0, i_byte};
                    n_idx  = w_idx + 4'd1;
                end else if (w_idx == FMT_IDX_BITS1) begin
                    // bits per sample must be exactly 8
                    if (r_fmt_bad || (i_byte != 8'd0) || (r_fval != FMT_BITS_8)) begin
                        n_verdict = V_BAD_FORMAT;
                        n_phase   = PH_DONE;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                    n_idx = 4'd0;
                end else begin
                    n_idx = w_idx + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign n_pos = (r_pos == PosMax) ? r_pos : r_pos + POSITION_BITS'(1);

    // summary as seen right after this byte
    always_comb begin
        o_info.found  = (n_verdict == V_FOUND);
        o_info.offset = 32'(n_foff);
        o_info.length = n_flen;
        o_info.size   = 32'(n_pos);
        if (n_verdict != V_UNDECIDED) begin
            o_info.status = n_verdict;
        end else begin
            case (n_phase)
                PH_RIFF:          o_info.status = ST_BAD_RIFF;
                PH_FLEN, PH_WAVE: o_info.status = ST_BAD_WAVE;
                default:          o_info.status = ST_NO_DATA;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase   <= PH_RIFF;
            r_pos     <= '0;
            r_idx     <= '0;
            r_tag     <= '0;
            r_fval    <= '0;
            r_cend    <= '0;
            r_foff    <= '0;
            r_flen    <= '0;
            r_verdict <= V_UNDECIDED;
            r_fmt_bad <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_idx     <= n_idx;
            r_tag     <= n_tag;
            r_fval    <= n_fval;
            r_cend    <= n_cend;
            r_foff    <= n_foff;
            r_flen    <= n_flen;
            r_verdict <= n_verdict;
            r_fmt_bad <= n_fmt_bad;
        end
    end

endmodule

// File: rtl/wssf_result.sv
// ----------------------------------------------------------------------------
// wssf_result
// Forms the output request: clamps the data length to the file end, or
// selects the raw fallback.
// ----------------------------------------------------------------------------
module wssf_result (
    input  wssf_pkg::t_span_info i_info,
    output wssf_pkg::t_out_req   o_req
);
    import wssf_pkg::*;

    logic [31:0] w_avail;

    // offset never passes the size, both saturate at the same limit
    assign w_avail = i_info.size - i_info.offset;

    always_comb begin
        if (i_info.found) begin
            o_req.sample_offset = i_info.offset;
            o_req.sample_length = (i_info.length > w_avail) ? w_avail : i_info.length;
            o_req.raw_fallback  = 1'b0;
            o_req.status        = ST_OK;
        end else begin
            o_req.sample_offset = 32'd0;
            o_req.sample_length = i_info.size;
            o_req.raw_fallback  = 1'b1;
            o_req.status        = i_info.status;
        end
    end

endmodule

// File: rtl/wav_sample_span_finder_unit.sv
// ----------------------------------------------------------------------------
// wav_sample_span_finder_unit
// Finds the 8-bit mono PCM sample span in a RIFF/WAVE byte stream.
// ----------------------------------------------------------------------------
// Throughput: one file byte per cycle, sustained, under no output stall.
// Result path: a final byte accepted at the input first sits in the input register;
//   the parse step, once the result slot is free, then loads the result register.
// Reset: i_rst_n low clears the parse state and the valid flags of both pipeline registers.
//   The parser also returns to its reset state after each final byte.
module wav_sample_span_finder_unit #(
    parameter int POSITION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wssf_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wssf_pkg::t_out_req o_out_req
);
    import wssf_pkg::*;

    // input register stage
    logic       r_in_vld;
    t_in_req    r_in_req;

    // result register stage
    logic       r_out_vld;
    t_out_req   r_out_req;

    logic       w_step;
    t_span_info w_info;
    t_out_req   w_res;

    // A byte is parsed unless it is the final one and the result slot is
    // still occupied; only the final byte produces a result, so every other
    // byte flows regardless of the output side.
    assign w_step     = r_in_vld && (!r_in_req.last_byte || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req <= i_in_req;
        end
    end

    wssf_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_byte (r_in_req.data_byte),
        .i_last (r_in_req.last_byte),
        .o_info (w_info)
    );

    wssf_result u_result (
        .i_info(w_info),
        .o_req (w_res)
    );

    // result register: loads on the final byte, drains on output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step && r_in_req.last_byte) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_req.last_byte) begin
            r_out_req <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out_req;

endmodule
